### sv/free_hole_segment_allocator_top_assert.svh
// Assertion macros used by the allocator RTL.
`ifndef FREE_HOLE_SEGMENT_ALLOCATOR_TOP_ASSERT_SVH
`define FREE_HOLE_SEGMENT_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define FHSA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("fhsa assertion failed");

// Next-cycle implication, disabled while in reset.
`define FHSA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("fhsa assertion failed");

`endif

### sv/fhsa_pkg.sv
// ----------------------------------------------------------------------------
// fhsa_pkg
// Types and constants of the free hole segment allocator.
// ----------------------------------------------------------------------------
package fhsa_pkg;

  localparam int ADDR_W  = 20;
  localparam int LEN_W   = 21;
  localparam int ENTRY_W = ADDR_W + LEN_W;
  localparam int CFG_W   = LEN_W;

  localparam logic [LEN_W-1:0] MEM_LIMIT = LEN_W'(1) << ADDR_W;
  localparam logic [LEN_W-1:0] LEN_MAX   = '1;

  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_OOM     = 2'd1;
  localparam logic [1:0] STAT_COMPACT = 2'd2;
  localparam logic [1:0] STAT_FULL    = 2'd3;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic [1:0] REG_FIT_MODE    = 2'd0;
  localparam logic [1:0] REG_MEMORY_SIZE = 2'd1;
  localparam logic [1:0] REG_RESERVED    = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_ALLOC_DEC,
    ST_FREE_DEC,
    ST_SHDN,
    ST_SHUP,
    ST_INS,
    ST_DONE
  } state_e;

endpackage

### sv/fhsa_ram.sv
// ----------------------------------------------------------------------------
// fhsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fhsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/free_hole_segment_allocator_top.sv
// ----------------------------------------------------------------------------
// free_hole_segment_allocator_top
// Free hole table with initialize, allocate (first/best/worst fit) and free.
//
// Input words carry operation, request_base and request_size; one result
// word (status, alloc_base, free_total) comes back per input word. Both
// channels use valid/stall. The hole table lives in one RAM with one write
// and one registered read port; a small sequencer walks it one entry per
// cycle, so the RAM port sets the pace:
//   initialize: write the one initial hole if it fits, then the result
//   allocate:   scan every entry, then shift the tail down if a hole is used up
//   free:       scan, then shift the tail down to merge or up to insert a hole
// The input stalls until the result is in the output register; the next word
// is taken while that result waits. A stalled receiver holds the result and,
// once the next item is done, the sequencer. Reset empties the table (count
// and total cleared) and loads fit_mode 0, memory_size 4096, reserved_size 128.
// ----------------------------------------------------------------------------
`include "free_hole_segment_allocator_top_assert.svh"

module free_hole_segment_allocator_top #(
  parameter int MAX_HOLES = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_index_i,
  input  logic [fhsa_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                operation_i,
  input  logic [fhsa_pkg::ADDR_W-1:0] request_base_i,
  input  logic [fhsa_pkg::LEN_W-1:0] request_size_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                status_o,
  output logic [fhsa_pkg::ADDR_W-1:0] alloc_base_o,
  output logic [fhsa_pkg::LEN_W-1:0] free_total_o
);

  import fhsa_pkg::*;

  localparam int IDX_W = $clog2(MAX_HOLES);
  localparam int CNT_W = $clog2(MAX_HOLES + 1);
  localparam int TOT_W = LEN_W + CNT_W;

  state_e state_q, state_d;

  logic [1:0]        fit_mode_q;
  logic [LEN_W-1:0]  mem_size_q, rsv_size_q;
  logic [CNT_W-1:0]  count_q;
  logic [TOT_W-1:0]  total_q;

  logic [1:0]        op_q;
  logic [ADDR_W-1:0] rb_q;
  logic [LEN_W-1:0]  rs_q;
  logic [1:0]        stat_q;
  logic [ADDR_W-1:0] ab_q;

  logic [CNT_W-1:0]  idx_q, rem_q, pos_q;
  logic              rd_pend_q;
  logic [IDX_W-1:0]  rd_idx_q;

  logic              sel_vld_q;
  logic [IDX_W-1:0]  sel_idx_q;
  logic [ADDR_W-1:0] sel_base_q;
  logic [LEN_W-1:0]  sel_len_q;

  logic              found_q, prv_vld_q;
  logic [ADDR_W-1:0] prv_base_q, nxt_base_q;
  logic [LEN_W-1:0]  prv_len_q, nxt_len_q;

  logic              out_vld_q;
  logic [1:0]        out_stat_q;
  logic [ADDR_W-1:0] out_ab_q;
  logic [LEN_W-1:0]  out_tot_q;

  logic               ram_we, rd_issue;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [ADDR_W-1:0]  rd_base;
  logic [LEN_W-1:0]   rd_len;

  logic [LEN_W-1:0]  mem_end;
  logic              in_acc, out_free, free_skip;
  logic [LEN_W:0]    top_sum;
  logic [LEN_W-1:0]  top_clip, fr_size;
  logic              jp, jn, fits, take;
  logic [CNT_W-1:0]  rem_alloc, rem_free;

  assign mem_end  = (mem_size_q > MEM_LIMIT) ? MEM_LIMIT : mem_size_q;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_vld_q || !out_stall_i;
  assign free_skip = (request_size_i == '0) ||
                     ({1'b0, request_base_i} >= mem_end);

  // Clip the freed region at the usable end.
  assign top_sum  = {2'b00, rb_q} + {1'b0, rs_q};
  assign top_clip = (top_sum > {1'b0, mem_end}) ? mem_end : top_sum[LEN_W-1:0];
  assign fr_size  = top_clip - {1'b0, rb_q};

  assign jp = prv_vld_q &&
              (({2'b00, prv_base_q} + {1'b0, prv_len_q}) == {2'b00, rb_q});
  assign jn = found_q && (top_clip == {1'b0, nxt_base_q});

  assign rd_base = ram_rdata[ENTRY_W-1:LEN_W];
  assign rd_len  = ram_rdata[LEN_W-1:0];

  assign fits = rd_len >= rs_q;
  assign take = fits && (!sel_vld_q ||
                ((fit_mode_q == FIT_BEST) && (rd_len < sel_len_q)) ||
                ((fit_mode_q == FIT_WORST) && (rd_len > sel_len_q)));

  assign rem_alloc = count_q - CNT_W'(sel_idx_q) - CNT_W'(1);
  assign rem_free  = count_q - pos_q - CNT_W'(1);

  fhsa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_HOLES)
  ) u_holes (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (operation_i)
            OP_INIT:  state_d = ST_INIT;
            OP_ALLOC: state_d = ST_SCAN;
            OP_FREE:  state_d = free_skip ? ST_DONE : ST_SCAN;
            default:  state_d = ST_DONE;
          endcase
        end
      end
      ST_INIT: state_d = ST_DONE;
      ST_SCAN: begin
        if (!rd_issue && !rd_pend_q) begin
          state_d = (op_q == OP_ALLOC) ? ST_ALLOC_DEC : ST_FREE_DEC;
        end
      end
      ST_ALLOC_DEC: begin
        if (sel_vld_q && (sel_len_q == rs_q) && (rem_alloc != '0)) begin
          state_d = ST_SHDN;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_FREE_DEC: begin
        if (jp && jn) begin
          state_d = (rem_free != '0) ? ST_SHDN : ST_DONE;
        end else if (jp || jn || (count_q >= CNT_W'(MAX_HOLES))) begin
          state_d = ST_DONE;
        end else if (pos_q < count_q) begin
          state_d = ST_SHUP;
        end else begin
          state_d = ST_INS;
        end
      end
      ST_SHDN: if ((rem_q == '0) && !rd_pend_q) state_d = ST_DONE;
      ST_SHUP: if ((rem_q == '0) && !rd_pend_q) state_d = ST_INS;
      ST_INS:  state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Table port control.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    rd_issue  = 1'b0;
    ram_raddr = idx_q[IDX_W-1:0];
    case (state_q)
      ST_INIT: begin
        if (rsv_size_q < mem_end) begin
          ram_we    = 1'b1;
          ram_wdata = {rsv_size_q[ADDR_W-1:0], mem_end - rsv_size_q};
        end
      end
      ST_SCAN: rd_issue = idx_q < count_q;
      ST_ALLOC_DEC: begin
        if (sel_vld_q && (sel_len_q > rs_q)) begin
          ram_we    = 1'b1;
          ram_waddr = sel_idx_q;
          ram_wdata = {sel_base_q + rs_q[ADDR_W-1:0], sel_len_q - rs_q};
        end
      end
      ST_FREE_DEC: begin
        if (jp) begin
          ram_we    = 1'b1;
          ram_waddr = IDX_W'(pos_q - CNT_W'(1));
          ram_wdata = {prv_base_q, prv_len_q + fr_size + (jn ? nxt_len_q : '0)};
        end else if (jn) begin
          ram_we    = 1'b1;
          ram_waddr = pos_q[IDX_W-1:0];
          ram_wdata = {rb_q, fr_size + nxt_len_q};
        end
      end
      ST_SHDN: begin
        rd_issue  = rem_q != '0;
        ram_we    = rd_pend_q;
        ram_waddr = rd_idx_q - IDX_W'(1);
        ram_wdata = ram_rdata;
      end
      ST_SHUP: begin
        rd_issue  = rem_q != '0;
        ram_we    = rd_pend_q;
        ram_waddr = rd_idx_q + IDX_W'(1);
        ram_wdata = ram_rdata;
      end
      ST_INS: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q[IDX_W-1:0];
        ram_wdata = {rb_q, fr_size};
      end
      default: ;
    endcase
  end

  assign in_stall_o = state_q != ST_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fit_mode_q <= FIT_FIRST;
      mem_size_q <= LEN_W'(4096);
      rsv_size_q <= LEN_W'(128);
      count_q    <= '0;
      total_q    <= '0;
      rd_pend_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= rd_issue;
      rd_idx_q  <= ram_raddr;

      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_FIT_MODE:    fit_mode_q <= cfg_data_i[1:0];
          REG_MEMORY_SIZE: mem_size_q <= cfg_data_i;
          REG_RESERVED:    rsv_size_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_vld_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            op_q      <= operation_i;
            rb_q      <= request_base_i;
            rs_q      <= request_size_i;
            stat_q    <= STAT_OK;
            ab_q      <= '0;
            idx_q     <= '0;
            pos_q     <= count_q;
            sel_vld_q <= 1'b0;
            found_q   <= 1'b0;
            prv_vld_q <= 1'b0;
          end
        end
        ST_INIT: begin
          if (rsv_size_q < mem_end) begin
            count_q <= CNT_W'(1);
            total_q <= TOT_W'(mem_end - rsv_size_q);
          end else begin
            count_q <= '0;
            total_q <= '0;
          end
        end
        ST_SCAN: begin
          if (rd_issue) idx_q <= idx_q + CNT_W'(1);
          if (rd_pend_q) begin
            if (op_q == OP_ALLOC) begin
              if (take) begin
                sel_vld_q  <= 1'b1;
                sel_idx_q  <= rd_idx_q;
                sel_base_q <= rd_base;
                sel_len_q  <= rd_len;
              end
            end else if (!found_q) begin
              // First base above the freed one marks the insert point.
              if (rd_base > rb_q) begin
                found_q    <= 1'b1;
                pos_q      <= CNT_W'(rd_idx_q);
                nxt_base_q <= rd_base;
                nxt_len_q  <= rd_len;
              end else begin
                prv_vld_q  <= 1'b1;
                prv_base_q <= rd_base;
                prv_len_q  <= rd_len;
              end
            end
          end
        end
        ST_ALLOC_DEC: begin
          if (!sel_vld_q) begin
            stat_q <= (total_q >= TOT_W'(rs_q)) ? STAT_COMPACT : STAT_OOM;
          end else begin
            ab_q    <= sel_base_q;
            total_q <= total_q - TOT_W'(rs_q);
            if (sel_len_q == rs_q) begin
              count_q <= count_q - CNT_W'(1);
              idx_q   <= CNT_W'(sel_idx_q) + CNT_W'(1);
              rem_q   <= rem_alloc;
            end
          end
        end
        ST_FREE_DEC: begin
          if (jp && jn) begin
            total_q <= total_q + TOT_W'(fr_size);
            count_q <= count_q - CNT_W'(1);
            idx_q   <= pos_q + CNT_W'(1);
            rem_q   <= rem_free;
          end else if (jp || jn) begin
            total_q <= total_q + TOT_W'(fr_size);
          end else if (count_q >= CNT_W'(MAX_HOLES)) begin
            stat_q <= STAT_FULL;
          end else begin
            // Open a slot: move the tail up, last entry first.
            idx_q <= count_q - CNT_W'(1);
            rem_q <= count_q - pos_q;
          end
        end
        ST_SHDN: begin
          if (rd_issue) begin
            idx_q <= idx_q + CNT_W'(1);
            rem_q <= rem_q - CNT_W'(1);
          end
        end
        ST_SHUP: begin
          if (rd_issue) begin
            idx_q <= idx_q - CNT_W'(1);
            rem_q <= rem_q - CNT_W'(1);
          end
        end
        ST_INS: begin
          count_q <= count_q + CNT_W'(1);
          total_q <= total_q + TOT_W'(fr_size);
        end
        ST_DONE: begin
          if (out_free) begin
            out_vld_q  <= 1'b1;
            out_stat_q <= stat_q;
            out_ab_q   <= ab_q;
            out_tot_q  <= (total_q > TOT_W'(LEN_MAX)) ? LEN_MAX : total_q[LEN_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o  = out_vld_q;
  assign status_o     = out_stat_q;
  assign alloc_base_o = out_ab_q;
  assign free_total_o = out_tot_q;

  `FHSA_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(MAX_HOLES))
  `FHSA_ASSERT_NOW(a_empty_total, clk_i, rst_ni, count_q == '0, total_q == '0)
  `FHSA_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_acc, state_q != ST_IDLE)
  `FHSA_ASSERT_NOW(a_scan_no_write, clk_i, rst_ni, state_q == ST_SCAN, !ram_we)

endmodule
